// File: sv/tle_pkg.sv
// Shared types and constants for the terminal line editor.
package tle_pkg;

  // Result word kinds
  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_LINE = 2'd2,
    KIND_LONG = 2'd3
  } kind_t;

  // Escape filter state
  typedef enum logic [1:0] {
    ESC_OFF   = 2'd0,
    ESC_INTRO = 2'd1,
    ESC_BODY  = 2'd2
  } esc_t;

  // Pending line end, used to fold CRLF / LFCR pairs
  typedef enum logic [1:0] {
    EOL_NONE = 2'd0,
    EOL_CR   = 2'd1,
    EOL_LF   = 2'd2
  } eol_t;

  // One result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [5:0]  position;
  } res_t;

  // Most result words one input byte can cause
  localparam int unsigned MAX_RES = 4;

  // Byte codes
  localparam logic [7:0] CH_ETX      = 8'h03;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_UPPER_C  = 8'h43;
  localparam logic [7:0] CH_BRACKET  = 8'h5B;
  localparam logic [7:0] CH_UPPER_O  = 8'h4F;
  localparam logic [7:0] CH_PARAM_LO = 8'h30;
  localparam logic [7:0] CH_PARAM_HI = 8'h3F;

endpackage

// File: sv/terminal_line_editor_core.sv
// Terminal line editor: byte in, echo / character / line-end words out.
// Latency: the first result word of a byte is offered the cycle after it is accepted.
// Throughput: a byte with N result words holds the output until all N have left; the next byte
// is taken in the cycle the previous byte's last word leaves (one byte a cycle when
// bytes cause no words). The four-entry result buffer sets the rate.
// Reset (rst, synchronous): escape filter idle, empty line, no overflow, echo on.
module terminal_line_editor_core #(
  parameter int unsigned LINE_BUF_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst,
  // input byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] byte_value,
  output logic [5:0] position,
  output logic       last,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       echo_enable
);

  localparam int unsigned LenW = (LINE_BUF_SIZE > 2) ? $clog2(LINE_BUF_SIZE) : 1;
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_BUF_SIZE - 1);

  // Editor state
  logic            echo_en;
  tle_pkg::esc_t   esc, esc_next;
  tle_pkg::eol_t   eol, eol_next;
  logic [LenW-1:0] len, len_next;
  logic            ovf, ovf_next;

  // Result buffer
  tle_pkg::res_t   res_new [tle_pkg::MAX_RES];
  logic [2:0]      cnt_new;
  tle_pkg::res_t   res_buf [tle_pkg::MAX_RES];
  logic [2:0]      res_left;
  logic [1:0]      res_idx;

  logic in_take;
  logic out_take;

  tle_step #(.LenW(LenW)) u_step (
    .in_byte  (in_byte),
    .echo_en  (echo_en),
    .esc      (esc),
    .eol      (eol),
    .len      (len),
    .ovf      (ovf),
    .len_max  (LenMax),
    .esc_next (esc_next),
    .eol_next (eol_next),
    .len_next (len_next),
    .ovf_next (ovf_next),
    .res      (res_new),
    .res_cnt  (cnt_new)
  );

  // Handshakes: a new byte enters once the buffer is empty or its last word leaves now
  assign cfg_ready = 1'b1;
  assign out_valid = (res_left != 3'd0);
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = !((res_left == 3'd0) || ((res_left == 3'd1) && out_take));
  assign in_take   = in_valid && !in_stall;

  // Output word
  assign kind       = res_buf[res_idx].kind;
  assign byte_value = res_buf[res_idx].byte_value;
  assign position   = res_buf[res_idx].position;
  assign last       = (res_left == 3'd1);

  // Control and editor state
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_en  <= 1'b1;
      esc      <= tle_pkg::ESC_OFF;
      eol      <= tle_pkg::EOL_NONE;
      len      <= '0;
      ovf      <= 1'b0;
      res_left <= 3'd0;
      res_idx  <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        echo_en <= echo_enable;
      end
      if (in_take) begin
        esc      <= esc_next;
        eol      <= eol_next;
        len      <= len_next;
        ovf      <= ovf_next;
        res_left <= cnt_new;
        res_idx  <= 2'd0;
      end else if (out_take) begin
        res_left <= res_left - 3'd1;
        res_idx  <= res_idx + 2'd1;
      end
    end
  end

  // Result payload, loaded per accepted byte
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_buf <= res_new;
    end
  end

endmodule

// File: sv/tle_step.sv
// Per-byte decode: next editor state and the list of result words for one byte.
module tle_step #(
  parameter int unsigned LenW = 6
) (
  input  logic [7:0]        in_byte,
  input  logic              echo_en,
  input  tle_pkg::esc_t     esc,
  input  tle_pkg::eol_t     eol,
  input  logic [LenW-1:0]   len,
  input  logic              ovf,
  input  logic [LenW-1:0]   len_max,
  output tle_pkg::esc_t     esc_next,
  output tle_pkg::eol_t     eol_next,
  output logic [LenW-1:0]   len_next,
  output logic              ovf_next,
  output tle_pkg::res_t     res [tle_pkg::MAX_RES],
  output logic [2:0]        res_cnt
);

  logic [LenW+5:0] len_ext;
  logic [5:0]      pos6;
  logic [2:0]      n;
  tle_pkg::eol_t   eol_kind;
  logic            is_eol;
  logic            printable;

  // Line length shown on 6 bits
  assign len_ext   = {6'd0, len};
  assign pos6      = len_ext[5:0];
  assign is_eol    = (in_byte == tle_pkg::CH_CR) || (in_byte == tle_pkg::CH_LF);
  assign eol_kind  = (in_byte == tle_pkg::CH_CR) ? tle_pkg::EOL_CR : tle_pkg::EOL_LF;
  assign printable = (in_byte >= tle_pkg::CH_SPACE) && (in_byte <= tle_pkg::CH_TILDE);
  assign res_cnt   = n;

  // Decode and build the result list in order, echo words only when enabled
  always_comb begin
    esc_next = esc;
    eol_next = eol;
    len_next = len;
    ovf_next = ovf;
    n        = 3'd0;
    for (int i = 0; i < tle_pkg::MAX_RES; i++) begin
      res[i] = '{tle_pkg::KIND_ECHO, 8'd0, 6'd0};
    end

    case (esc)
      tle_pkg::ESC_INTRO: begin
        esc_next = ((in_byte == tle_pkg::CH_BRACKET) || (in_byte == tle_pkg::CH_UPPER_O))
                   ? tle_pkg::ESC_BODY : tle_pkg::ESC_OFF;
      end
      tle_pkg::ESC_BODY: begin
        if ((in_byte < tle_pkg::CH_PARAM_LO) || (in_byte > tle_pkg::CH_PARAM_HI)) begin
          esc_next = tle_pkg::ESC_OFF;
        end
      end
      default: begin
        esc_next = tle_pkg::ESC_OFF;
        if (in_byte == tle_pkg::CH_ESC) begin
          esc_next = tle_pkg::ESC_INTRO;
        end else if (is_eol) begin
          if ((eol != tle_pkg::EOL_NONE) && (eol != eol_kind)) begin
            // second half of a CRLF / LFCR pair
            eol_next = tle_pkg::EOL_NONE;
          end else begin
            eol_next = eol_kind;
            if (echo_en) begin
              res[0] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_CR, 6'd0};
              res[1] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_LF, 6'd0};
              n = 3'd2;
            end
            if (ovf) begin
              res[n[1:0]] = '{tle_pkg::KIND_LONG, 8'd0, 6'd0};
            end else begin
              res[n[1:0]] = '{tle_pkg::KIND_LINE, 8'd0, pos6};
            end
            n        = n + 3'd1;
            len_next = '0;
            ovf_next = 1'b0;
          end
        end else begin
          eol_next = tle_pkg::EOL_NONE;
          if ((in_byte == tle_pkg::CH_BS) || (in_byte == tle_pkg::CH_DEL)) begin
            if (len != '0) begin
              len_next = len - LenW'(1);
              if (echo_en) begin
                res[0] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 6'd0};
                res[1] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE, 6'd0};
                res[2] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 6'd0};
                n = 3'd3;
              end
            end
          end else if (in_byte == tle_pkg::CH_ETX) begin
            len_next = '0;
            ovf_next = 1'b0;
            if (echo_en) begin
              res[0] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_CARET, 6'd0};
              res[1] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_UPPER_C, 6'd0};
              res[2] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_CR, 6'd0};
              res[3] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_LF, 6'd0};
              n = 3'd4;
            end
          end else if (printable) begin
            if (len >= len_max) begin
              ovf_next = 1'b1;
            end else begin
              len_next = len + LenW'(1);
              res[0] = '{tle_pkg::KIND_CHAR, in_byte, pos6};
              n = 3'd1;
              if (echo_en) begin
                res[1] = '{tle_pkg::KIND_ECHO, in_byte, 6'd0};
                n = 3'd2;
              end
            end
          end
        end
      end
    endcase
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for terminal_line_editor_core: byte streams checked word by word.
module tb;

  localparam int unsigned LINE_BUF_SIZE = 64;
  localparam int unsigned LINE_MAX      = LINE_BUF_SIZE - 1;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          MAX_GAP       = 13;

  // One expected result word
  typedef struct packed {
    tle_pkg::kind_t kind;
    logic [7:0]     byte_value;
    logic [5:0]     position;
    logic           last;
  } word_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte     = 8'h00;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [5:0] position;
  logic       last;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic       echo_enable = 1'b1;

  // Line editor state as the testbench sees it
  tle_pkg::esc_t esc_st   = tle_pkg::ESC_OFF;
  tle_pkg::eol_t eol_st   = tle_pkg::EOL_NONE;
  int unsigned   line_len = 0;
  bit            overflow = 1'b0;
  bit            echo_on  = 1'b1;

  word_t due_words[$];
  int    errors     = 0;
  int    cycles     = 0;
  int    stall_left = 0;
  int    typed      = 0;
  bit    idle_on    = 1'b1;

  terminal_line_editor_core #(
    .LINE_BUF_SIZE(LINE_BUF_SIZE)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .byte_value (byte_value),
    .position   (position),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .echo_enable(echo_enable)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("terminal_line_editor_core test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic add_word(input tle_pkg::kind_t k, input logic [7:0] v,
                          input logic [5:0] p);
    word_t w;
    w.kind       = k;
    w.byte_value = v;
    w.position   = p;
    w.last       = 1'b0;
    due_words.push_back(w);
  endtask

  task automatic add_echo(input logic [7:0] v);
    if (echo_on) add_word(tle_pkg::KIND_ECHO, v, 6'd0);
  endtask

  // Advance the editor state by one byte and queue the words it causes
  task automatic line_edit(input logic [7:0] b);
    int unsigned   first_cnt;
    tle_pkg::eol_t eol_new;
    word_t         w;
    first_cnt = due_words.size();
    eol_new   = (b == tle_pkg::CH_CR) ? tle_pkg::EOL_CR : tle_pkg::EOL_LF;
    if (esc_st == tle_pkg::ESC_INTRO) begin
      esc_st = (b == tle_pkg::CH_BRACKET || b == tle_pkg::CH_UPPER_O)
               ? tle_pkg::ESC_BODY : tle_pkg::ESC_OFF;
    end else if (esc_st == tle_pkg::ESC_BODY) begin
      if (b < tle_pkg::CH_PARAM_LO || b > tle_pkg::CH_PARAM_HI) esc_st = tle_pkg::ESC_OFF;
    end else if (b == tle_pkg::CH_ESC) begin
      esc_st = tle_pkg::ESC_INTRO;
    end else if (b == tle_pkg::CH_CR || b == tle_pkg::CH_LF) begin
      // second half of a CRLF / LFCR pair is folded away
      if (eol_st != tle_pkg::EOL_NONE && eol_st != eol_new) begin
        eol_st = tle_pkg::EOL_NONE;
      end else begin
        eol_st = eol_new;
        add_echo(tle_pkg::CH_CR);
        add_echo(tle_pkg::CH_LF);
        if (overflow) add_word(tle_pkg::KIND_LONG, 8'h00, 6'd0);
        else add_word(tle_pkg::KIND_LINE, 8'h00, 6'(line_len));
        line_len = 0;
        overflow = 1'b0;
      end
    end else begin
      eol_st = tle_pkg::EOL_NONE;
      if (b == tle_pkg::CH_BS || b == tle_pkg::CH_DEL) begin
        if (line_len > 0) begin
          line_len--;
          add_echo(tle_pkg::CH_BS);
          add_echo(tle_pkg::CH_SPACE);
          add_echo(tle_pkg::CH_BS);
        end
      end else if (b == tle_pkg::CH_ETX) begin
        line_len = 0;
        overflow = 1'b0;
        add_echo(tle_pkg::CH_CARET);
        add_echo(tle_pkg::CH_UPPER_C);
        add_echo(tle_pkg::CH_CR);
        add_echo(tle_pkg::CH_LF);
      end else if (b >= tle_pkg::CH_SPACE && b <= tle_pkg::CH_TILDE) begin
        if (line_len >= LINE_MAX) begin
          overflow = 1'b1;
        end else begin
          add_word(tle_pkg::KIND_CHAR, b, 6'(line_len));
          line_len++;
          add_echo(b);
        end
      end
    end
    // flag the final word of this byte
    if (due_words.size() > first_cnt) begin
      w      = due_words.pop_back();
      w.last = 1'b1;
      due_words.push_back(w);
    end
  endtask

  // Send one byte; valid stays high after acceptance until the next call or settle
  task automatic type_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    line_edit(b);
  endtask

  // Let every expected word drain, then idle on for bytes with no words
  task automatic settle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_echo(input bit v);
    settle();
    cfg_valid   <= 1'b1;
    echo_enable <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    echo_on = v;
  endtask

  // Result side: check each accepted word, then draw the next stall
  always @(posedge clk) begin
    word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d byte=%h pos=%0d last=%b",
                                  kind, byte_value, position, last));
      end else begin
        exp_w = due_words.pop_front();
        if (kind !== exp_w.kind || byte_value !== exp_w.byte_value ||
            position !== exp_w.position || last !== exp_w.last)
          report_mismatch($sformatf(
            "got kind=%0d byte=%h pos=%0d last=%b, want kind=%0d byte=%h pos=%0d last=%b",
            kind, byte_value, position, last,
            exp_w.kind, exp_w.byte_value, exp_w.position, exp_w.last));
      end
      stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(tle_pkg::CH_SPACE, tle_pkg::CH_TILDE));
  endfunction

  // Printable bytes, then CRLF and LFCR line endings
  task automatic test_line_ends();
    type_byte(8'h41);
    type_byte(tle_pkg::CH_TILDE);
    type_byte(tle_pkg::CH_SPACE);
    type_byte(tle_pkg::CH_CR);
    type_byte(tle_pkg::CH_LF);
    type_byte(tle_pkg::CH_LF);
    type_byte(tle_pkg::CH_CR);
  endtask

  // Erase on an empty line, then DEL on a real character and BS on the emptied line
  task automatic test_erase();
    type_byte(tle_pkg::CH_BS);
    type_byte(8'h78);
    type_byte(tle_pkg::CH_DEL);
    type_byte(tle_pkg::CH_BS);
  endtask

  task automatic test_ctrl_c();
    type_byte(8'h71);
    type_byte(tle_pkg::CH_ETX);
  endtask

  // CSI with parameters, a bad introducer, and a sequence between CR and LF
  task automatic test_escapes();
    type_byte(tle_pkg::CH_ESC);
    type_byte(tle_pkg::CH_BRACKET);
    type_byte(tle_pkg::CH_PARAM_LO);
    type_byte(tle_pkg::CH_PARAM_HI);
    type_byte(8'h41);
    type_byte(tle_pkg::CH_ESC);
    type_byte(8'h78);
    type_byte(tle_pkg::CH_CR);
    type_byte(tle_pkg::CH_ESC);
    type_byte(tle_pkg::CH_UPPER_O);
    type_byte(8'h42);
    type_byte(tle_pkg::CH_LF);
  endtask

  // Dropped bytes clear the pending line end, so each CR is its own line
  task automatic test_dropped();
    type_byte(tle_pkg::CH_CR);
    type_byte(8'h80);
    type_byte(tle_pkg::CH_CR);
    type_byte(8'hFF);
  endtask

  // Fill past the end, erase while overflowed, refill, then end the line
  task automatic test_long_line();
    type_byte(tle_pkg::CH_ETX);
    repeat (LINE_MAX + 2) type_byte(rand_printable());
    type_byte(tle_pkg::CH_DEL);
    type_byte(rand_printable());
    type_byte(tle_pkg::CH_CR);
    type_byte(8'h61);
    type_byte(tle_pkg::CH_LF);
  endtask

  // One well-formed token of terminal input, or noise
  task automatic random_token();
    int         pick;
    int         n;
    logic [7:0] intro;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      type_byte(rand_printable());
      typed++;
    end else if (pick < 55) begin
      type_byte($urandom_range(0, 1) ? tle_pkg::CH_BS : tle_pkg::CH_DEL);
      typed++;
    end else if (pick < 65) begin
      case ($urandom_range(0, 3))
        0: type_byte(tle_pkg::CH_CR);
        1: type_byte(tle_pkg::CH_LF);
        2: begin
          type_byte(tle_pkg::CH_CR);
          type_byte(tle_pkg::CH_LF);
        end
        default: begin
          type_byte(tle_pkg::CH_LF);
          type_byte(tle_pkg::CH_CR);
        end
      endcase
      typed++;
    end else if (pick < 68) begin
      type_byte(tle_pkg::CH_ETX);
      typed++;
    end else if (pick < 78) begin
      type_byte(tle_pkg::CH_ESC);
      case ($urandom_range(0, 4))
        0, 1:    intro = tle_pkg::CH_BRACKET;
        2:       intro = tle_pkg::CH_UPPER_O;
        default: intro = 8'($urandom_range(0, 255));
      endcase
      type_byte(intro);
      if (intro == tle_pkg::CH_BRACKET || intro == tle_pkg::CH_UPPER_O) begin
        n = $urandom_range(0, 3);
        repeat (n) type_byte(8'($urandom_range(tle_pkg::CH_PARAM_LO, tle_pkg::CH_PARAM_HI)));
        if ($urandom_range(0, 4) == 0) type_byte(8'($urandom_range(0, 255)));
        else type_byte(8'($urandom_range(8'h40, tle_pkg::CH_TILDE)));
      end
    end else if (pick < 80) begin
      n = $urandom_range(50, 70);
      repeat (n) type_byte(rand_printable());
      typed += n;
    end else begin
      type_byte(8'($urandom_range(0, 255)));
      typed++;
    end
  endtask

  task automatic test_random(input bit echo_v, input bit idle_v, input int target);
    set_echo(echo_v);
    idle_on = idle_v;
    typed   = 0;
    while (typed < target) random_token();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_echo(1'b1);
    test_line_ends();
    test_erase();
    test_ctrl_c();
    test_escapes();
    test_dropped();
    test_long_line();
    test_random(1'b1, 1'b1, 75);
    test_random(1'b0, 1'b0, 35);
    test_random(1'b0, 1'b1, 25);
    test_random(1'b1, 1'b1, 60);
    settle();
    if (errors == 0) begin
      $display("terminal_line_editor_core test passed");
    end else begin
      $display("terminal_line_editor_core test failed");
    end
    $finish;
  end

endmodule
